// File: hdl/bsmt_pkg.sv
package bsmt_pkg;

   localparam int ELEM_W = 32;
   localparam int REQ_W  = 2;
   localparam int CNT_W  = 5;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_SPARE  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINAL,
      ST_RESP
   } state_type;

endpackage

// File: hdl/bsmt_ram.sv
module bsmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bounded_set_membership_table.sv
// Bounded set of distinct signed 32-bit integers held in CAPACITY slots.
// Each item adds, removes or looks up one element (code 3 acts as a lookup);
// the result says whether the element was there before, whether an add of a
// new element was dropped because every slot was used, and gives the count,
// an empty flag and the signed minimum and maximum after the item (both zero
// when the set is empty). An item passes through the scan, drain and final
// states from acceptance to a valid result: the value table has one read
// port and is scanned one slot per cycle through a single match and
// min/max compare stage, followed by a drain state for the last read and a
// final state that updates the table. req_ready is low from acceptance
// until the result is taken; the result stays on the rsp_ ports until
// rsp_ready, so a new item is accepted only after the last result is taken.
// The table comes up empty after reset with no clearing pass.
module bounded_set_membership_table #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bsmt_pkg::REQ_W-1:0]         req_type,
   input  logic signed [bsmt_pkg::ELEM_W-1:0] req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_was_present,
   output logic                               rsp_dropped_full,
   output logic [bsmt_pkg::CNT_W-1:0]         rsp_member_count,
   output logic                               rsp_set_empty,
   output logic signed [bsmt_pkg::ELEM_W-1:0] rsp_min_element,
   output logic signed [bsmt_pkg::ELEM_W-1:0] rsp_max_element
);

   import bsmt_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   state_type state_ff, state_in;

   logic [CAPACITY-1:0]      valid_ff, valid_in;
   req_code_type             code_ff, code_in;
   logic signed [ELEM_W-1:0] elem_ff, elem_in;

   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;

   logic                     match_ff, match_in;
   logic [IW-1:0]            match_idx_ff, match_idx_in;
   logic                     free_ff, free_in;
   logic [IW-1:0]            free_idx_ff, free_idx_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic signed [ELEM_W-1:0] lo_ff, lo_in;
   logic signed [ELEM_W-1:0] hi_ff, hi_in;

   logic                     was_present_ff, was_present_in;
   logic                     dropped_ff, dropped_in;
   logic [CNT_W-1:0]         count_out_ff, count_out_in;
   logic                     empty_ff, empty_in;
   logic signed [ELEM_W-1:0] min_out_ff, min_out_in;
   logic signed [ELEM_W-1:0] max_out_ff, max_out_in;

   logic                     ram_wr_en;
   logic [IW-1:0]            ram_wr_addr;
   logic                     ram_rd_en;
   logic [ELEM_W-1:0]        ram_rd_data;
   logic signed [ELEM_W-1:0] rd_value;

   logic          keep_elem;
   logic [CW-1:0] total;

   bsmt_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (CAPACITY)
   ) u_values (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (elem_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_value = signed'(ram_rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff        <= code_in;
      elem_ff        <= elem_in;
      scan_idx_ff    <= scan_idx_in;
      chk_idx_ff     <= chk_idx_in;
      match_ff       <= match_in;
      match_idx_ff   <= match_idx_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      cnt_ff         <= cnt_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      was_present_ff <= was_present_in;
      dropped_ff     <= dropped_in;
      count_out_ff   <= count_out_in;
      empty_ff       <= empty_in;
      min_out_ff     <= min_out_in;
      max_out_ff     <= max_out_in;
   end

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      code_in        = code_ff;
      elem_in        = elem_ff;
      scan_idx_in    = scan_idx_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = scan_idx_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      cnt_in         = cnt_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      was_present_in = was_present_ff;
      dropped_in     = dropped_ff;
      count_out_in   = count_out_ff;
      empty_in       = empty_ff;
      min_out_in     = min_out_ff;
      max_out_in     = max_out_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = free_idx_ff;
      ram_rd_en      = 1'b0;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      keep_elem      = 1'b0;
      total          = cnt_ff;

      // one slot checked per cycle, in the cycle after its read
      if (chk_vld_ff) begin
         if (valid_ff[chk_idx_ff]) begin
            if (rd_value == elem_ff) begin
               match_in     = 1'b1;
               match_idx_in = chk_idx_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == '0) begin
                  lo_in = rd_value;
                  hi_in = rd_value;
               end else begin
                  if (rd_value < lo_ff) lo_in = rd_value;
                  if (rd_value > hi_ff) hi_in = rd_value;
               end
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               code_in     = req_code_type'(req_type);
               elem_in     = req_element;
               scan_idx_in = '0;
               match_in    = 1'b0;
               free_in     = 1'b0;
               cnt_in      = '0;
               lo_in       = '0;
               hi_in       = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ram_rd_en  = 1'b1;
            chk_vld_in = 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            // element is in the set afterward unless removed or never added
            if (match_ff) begin
               keep_elem = (code_ff != REQ_REMOVE);
            end else begin
               keep_elem = (code_ff == REQ_ADD) && free_ff;
            end
            total = cnt_ff + CW'(keep_elem);
            if (code_ff == REQ_ADD && !match_ff && free_ff) begin
               ram_wr_en             = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
            end
            if (code_ff == REQ_REMOVE && match_ff) begin
               valid_in[match_idx_ff] = 1'b0;
            end
            was_present_in = match_ff;
            dropped_in     = (code_ff == REQ_ADD) && !match_ff && !free_ff;
            count_out_in   = CNT_W'(total);
            empty_in       = (total == '0);
            min_out_in     = lo_ff;
            max_out_in     = hi_ff;
            if (keep_elem && (cnt_ff == '0 || elem_ff < lo_ff)) min_out_in = elem_ff;
            if (keep_elem && (cnt_ff == '0 || elem_ff > hi_ff)) max_out_in = elem_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_was_present  = was_present_ff;
   assign rsp_dropped_full = dropped_ff;
   assign rsp_member_count = count_out_ff;
   assign rsp_set_empty    = empty_ff;
   assign rsp_min_element  = min_out_ff;
   assign rsp_max_element  = max_out_ff;

endmodule

// File: tb/bounded_set_membership_table_tb.sv
module bounded_set_membership_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsmt_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_LIMIT = 200;
   localparam int POOL_SIZE = 20;
   localparam int MAX_PRINTED = 100;

   localparam int STYLE_FILL = 0;
   localparam int STYLE_MIXED = 1;
   localparam int STYLE_DRAIN = 2;

   localparam logic signed [ELEM_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [ELEM_W-1:0] MOST_POS = 32'sh7fff_ffff;

   typedef struct packed {
      logic              was_present;
      logic              dropped_full;
      logic [CNT_W-1:0]  member_count;
      logic              set_empty;
      logic [ELEM_W-1:0] min_element;
      logic [ELEM_W-1:0] max_element;
   } set_result_type;

   typedef struct {
      req_code_type             code;
      logic signed [ELEM_W-1:0] value;
      bit                       known;
      set_result_type           want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [REQ_W-1:0] req_type = REQ_QUERY;
   logic signed [ELEM_W-1:0] req_element = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_was_present;
   logic rsp_dropped_full;
   logic [CNT_W-1:0] rsp_member_count;
   logic rsp_set_empty;
   logic signed [ELEM_W-1:0] rsp_min_element;
   logic signed [ELEM_W-1:0] rsp_max_element;

   bit slot_used [CAPACITY];
   logic signed [ELEM_W-1:0] slot_value [CAPACITY];
   logic signed [ELEM_W-1:0] element_pool [POOL_SIZE];

   set_result_type expected_results [$];
   stim_row_type directed_plan [$];

   int items_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int drops_seen = 0;
   int remove_hits = 0;
   int empty_seen = 0;
   int full_seen = 0;
   int idle_cycles = 0;
   bit send_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   bounded_set_membership_table #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_was_present(rsp_was_present),
      .rsp_dropped_full(rsp_dropped_full),
      .rsp_member_count(rsp_member_count),
      .rsp_set_empty(rsp_set_empty),
      .rsp_min_element(rsp_min_element),
      .rsp_max_element(rsp_max_element)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic set_result_type result_of(input bit wp, input bit df, input int cnt,
                                                input bit emp, input logic [ELEM_W-1:0] lo,
                                                input logic [ELEM_W-1:0] hi);
      set_result_type r;
      r.was_present = wp;
      r.dropped_full = df;
      r.member_count = cnt[CNT_W-1:0];
      r.set_empty = emp;
      r.min_element = lo;
      r.max_element = hi;
      return r;
   endfunction

   // updates the table copy and returns the result of one item
   function automatic set_result_type apply_request(input req_code_type code,
                                                    input logic signed [ELEM_W-1:0] value);
      set_result_type r;
      int i;
      int hit;
      int hole;
      int count;
      logic signed [ELEM_W-1:0] lo;
      logic signed [ELEM_W-1:0] hi;
      hit = -1;
      hole = -1;
      count = 0;
      lo = '0;
      hi = '0;
      r = '0;
      for (i = 0; i < CAPACITY; i++) begin
         if (slot_used[i]) begin
            if (hit < 0 && slot_value[i] == value) hit = i;
         end else if (hole < 0) begin
            hole = i;
         end
      end
      if (code == REQ_ADD) begin
         if (hit < 0) begin
            if (hole >= 0) begin
               slot_used[hole] = 1'b1;
               slot_value[hole] = value;
            end else begin
               r.dropped_full = 1'b1;
            end
         end
      end else if (code == REQ_REMOVE) begin
         if (hit >= 0) slot_used[hit] = 1'b0;
      end
      for (i = 0; i < CAPACITY; i++) begin
         if (slot_used[i]) begin
            if (count == 0 || slot_value[i] < lo) lo = slot_value[i];
            if (count == 0 || slot_value[i] > hi) hi = slot_value[i];
            count++;
         end
      end
      r.was_present = (hit >= 0);
      r.member_count = count[CNT_W-1:0];
      r.set_empty = (count == 0);
      r.min_element = lo;
      r.max_element = hi;
      return r;
   endfunction

   task automatic add_row(input req_code_type code, input logic signed [ELEM_W-1:0] value,
                          input bit known, input set_result_type want);
      stim_row_type row;
      row.code = code;
      row.value = value;
      row.known = known;
      row.want = want;
      directed_plan.push_back(row);
   endtask

   task automatic report_mismatch(input string what, input logic [ELEM_W-1:0] got,
                                  input logic [ELEM_W-1:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch at result %0d: %s got %h expected %h",
                  results_checked, what, got, want);
   endtask

   task automatic send_item(input req_code_type code, input logic signed [ELEM_W-1:0] value,
                            input bit known, input set_result_type want);
      int gap;
      set_result_type predicted;
      gap = send_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_element <= value;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(code, value);
      expected_results.push_back(known ? want : predicted);
      items_sent++;
      if (predicted.dropped_full) drops_seen++;
      if (code == REQ_REMOVE && predicted.was_present) remove_hits++;
      if (predicted.set_empty) empty_seen++;
      if (predicted.member_count == CAPACITY) full_seen++;
   endtask

   function automatic req_code_type pick_code(input int style);
      int roll;
      int add_cut;
      int remove_cut;
      roll = $urandom_range(0, 99);
      case (style)
         STYLE_FILL: begin
            add_cut = 65;
            remove_cut = 80;
         end
         STYLE_DRAIN: begin
            add_cut = 15;
            remove_cut = 75;
         end
         default: begin
            add_cut = 40;
            remove_cut = 70;
         end
      endcase
      if (roll < add_cut) return REQ_ADD;
      if (roll < remove_cut) return REQ_REMOVE;
      if (roll < 94) return REQ_QUERY;
      return REQ_SPARE;
   endfunction

   function automatic logic signed [ELEM_W-1:0] pick_element();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return element_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("bounded_set_membership_table_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : result_side
      int stall;
      set_result_type got;
      set_result_type want;
      while (reset) @(posedge clock);
      forever begin
         if (results_checked % 64 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         stall = rsp_quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = result_of(rsp_was_present, rsp_dropped_full, int'(rsp_member_count),
                         rsp_set_empty, rsp_min_element, rsp_max_element);
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending, count",
                            ELEM_W'(got.member_count), '0);
         end else begin
            want = expected_results.pop_front();
            if (got.was_present !== want.was_present)
               report_mismatch("was_present", ELEM_W'(got.was_present),
                               ELEM_W'(want.was_present));
            if (got.dropped_full !== want.dropped_full)
               report_mismatch("dropped_full", ELEM_W'(got.dropped_full),
                               ELEM_W'(want.dropped_full));
            if (got.member_count !== want.member_count)
               report_mismatch("member_count", ELEM_W'(got.member_count),
                               ELEM_W'(want.member_count));
            if (got.set_empty !== want.set_empty)
               report_mismatch("set_empty", ELEM_W'(got.set_empty),
                               ELEM_W'(want.set_empty));
            if (got.min_element !== want.min_element)
               report_mismatch("min_element", got.min_element, want.min_element);
            if (got.max_element !== want.max_element)
               report_mismatch("max_element", got.max_element, want.max_element);
         end
         results_checked++;
      end
   end

   initial begin : request_side
      int k;
      int block;
      int style;
      int directed_count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extremes, duplicates, spare code, fill to capacity
      add_row(REQ_QUERY, 32'sd0, 1'b1, result_of(1'b0, 1'b0, 0, 1'b1, 0, 0));
      add_row(REQ_REMOVE, 32'sd5, 1'b1, result_of(1'b0, 1'b0, 0, 1'b1, 0, 0));
      add_row(REQ_ADD, MOST_NEG, 1'b1, result_of(1'b0, 1'b0, 1, 1'b0, MOST_NEG, MOST_NEG));
      add_row(REQ_ADD, MOST_POS, 1'b1, result_of(1'b0, 1'b0, 2, 1'b0, MOST_NEG, MOST_POS));
      add_row(REQ_ADD, MOST_NEG, 1'b1, result_of(1'b1, 1'b0, 2, 1'b0, MOST_NEG, MOST_POS));
      add_row(REQ_SPARE, MOST_POS, 1'b1, result_of(1'b1, 1'b0, 2, 1'b0, MOST_NEG, MOST_POS));
      add_row(REQ_QUERY, -32'sd1, 1'b0, '0);
      add_row(REQ_ADD, 32'sd0, 1'b0, '0);
      add_row(REQ_ADD, -32'sd1, 1'b0, '0);
      add_row(REQ_ADD, 32'sd1, 1'b0, '0);
      add_row(REQ_ADD, 32'sh5555_5555, 1'b0, '0);
      add_row(REQ_ADD, 32'shaaaa_aaaa, 1'b0, '0);
      add_row(REQ_ADD, 32'sd2, 1'b0, '0);
      add_row(REQ_ADD, -32'sd2, 1'b0, '0);
      add_row(REQ_ADD, 32'sd100, 1'b0, '0);
      add_row(REQ_ADD, -32'sd100, 1'b0, '0);
      add_row(REQ_ADD, 32'sh7fff_fffe, 1'b0, '0);
      add_row(REQ_ADD, 32'sh8000_0001, 1'b0, '0);
      add_row(REQ_ADD, 32'sd7, 1'b0, '0);
      add_row(REQ_ADD, 32'sd8, 1'b0, '0);
      add_row(REQ_ADD, 32'sd9, 1'b0, '0);
      add_row(REQ_ADD, 32'sd12345, 1'b1,
              result_of(1'b0, 1'b1, 16, 1'b0, MOST_NEG, MOST_POS));
      add_row(REQ_ADD, 32'sd0, 1'b1, result_of(1'b1, 1'b0, 16, 1'b0, MOST_NEG, MOST_POS));
      add_row(REQ_REMOVE, MOST_NEG, 1'b0, '0);
      add_row(REQ_ADD, 32'sd12345, 1'b0, '0);

      for (k = 0; k < directed_plan.size(); k++)
         send_item(directed_plan[k].code, directed_plan[k].value,
                   directed_plan[k].known, directed_plan[k].want);
      directed_count = items_sent;

      // small pool, a bit larger than the table, so hits and full drops are common
      element_pool[0] = MOST_NEG;
      element_pool[1] = MOST_POS;
      element_pool[2] = '0;
      element_pool[3] = -32'sd1;
      for (k = 4; k < POOL_SIZE; k++) element_pool[k] = $urandom;

      style = STYLE_MIXED;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) begin
            block = k / 100;
            case (block % 4)
               0: style = STYLE_FILL;
               1: style = STYLE_MIXED;
               2: style = STYLE_DRAIN;
               default: style = $urandom_range(STYLE_FILL, STYLE_DRAIN);
            endcase
            send_quiet = (block % 5 == 3);
         end
         send_item(pick_code(style), pick_element(), 1'b0, '0);
         if (k % 400 == 399) begin
            req_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      $display("covered %0d items (%0d directed), %0d adds dropped on a full table,",
               items_sent, directed_count, drops_seen);
      $display("%0d removes of present elements, %0d full and %0d empty results, %0d mismatches",
               remove_hits, full_seen, empty_seen, mismatches);
      if (mismatches == 0) begin
         $display("bounded_set_membership_table_tb OK");
      end else begin
         $display("bounded_set_membership_table_tb NOT OK");
      end
      $finish;
   end

endmodule
